// ----- hdl/rpwc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpwc_pkg: shared types and constants for the read pair window clusterer
// Holds the channel payload structs, status codes, register indexes and the
// strand decode of the alignment flag word.
// ----------------------------------------------------------------------------
package rpwc_pkg;

  localparam int POS_BITS = 28;

  typedef struct packed {
    logic [2:0]          chrom_code;
    logic [11:0]         sam_flag;
    logic [7:0]          mapq;
    logic                mate_same_ref;
    logic [POS_BITS-1:0] read_pos;
    logic [POS_BITS-1:0] mate_pos;
  } rpwc_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_reverse;
    logic [8:0] joined_count;
    logic [7:0] cluster_index;
  } rpwc_out_t;

  localparam logic [2:0] ST_JOINED   = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_LOW_QUAL = 3'd2;
  localparam logic [2:0] ST_SPAN     = 3'd3;
  localparam logic [2:0] ST_CHROM    = 3'd4;
  localparam logic [2:0] ST_FLAG     = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_MIN_QUAL = 2'd1;
  localparam logic [1:0] REG_MIN_SPAN = 2'd2;

  localparam int         CFG_W     = 28;
  localparam logic [2:0] CHROM_MAX = 3'd4;
  localparam logic [8:0] JOIN_MAX  = 9'd511;

  // Classified item handed from front to back.
  typedef struct packed {
    logic                kept;
    logic [2:0]          status;
    logic                rev;
    logic [2:0]          chrom;
    logic [POS_BITS-1:0] read_pos;
    logic [POS_BITS-1:0] mate_pos;
  } rpwc_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } rpwc_bk_state_t;

  // 0 forward, 1 reverse; known set when flag is one of the eight codes.
  function automatic logic [1:0] strand_of(input logic [11:0] flag);
    logic [1:0] r;
    begin
      case (flag)
        12'd113, 12'd177, 12'd2113, 12'd2177: r = 2'b11;
        12'd65, 12'd129, 12'd2161, 12'd2225:  r = 2'b10;
        default:                              r = 2'b00;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- hdl/rpwc_front.sv -----
// ----------------------------------------------------------------------------
// rpwc_front: input filter
// Runs the quality, span, chromosome and flag tests and registers a job.
// ----------------------------------------------------------------------------
module rpwc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  rpwc_pkg::rpwc_in_t  item,
  input  logic [7:0]          min_quality,
  input  logic [27:0]         min_span,
  output logic                job_valid,
  output rpwc_pkg::rpwc_job_t job
);
  import rpwc_pkg::*;

  logic      job_valid_r;
  rpwc_job_t job_r, job_nxt;
  logic [1:0] sd;
  logic [28:0] lim;

  always_comb begin
    sd  = strand_of(item.sam_flag);
    lim = {1'b0, item.read_pos} + {1'b0, min_span};
    job_nxt = '0;
    job_nxt.chrom    = item.chrom_code;
    job_nxt.read_pos = item.read_pos;
    job_nxt.mate_pos = item.mate_pos;
    if (item.mapq < min_quality || !item.mate_same_ref) begin
      job_nxt.status = ST_LOW_QUAL;
    end else if ({1'b0, item.mate_pos} <= lim) begin
      job_nxt.status = ST_SPAN;
    end else if (item.chrom_code > CHROM_MAX) begin
      job_nxt.status = ST_CHROM;
    end else if (!sd[1]) begin
      job_nxt.status = ST_FLAG;
    end else begin
      job_nxt.kept = 1'b1;
      job_nxt.rev  = sd[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= take;
    end
    if (take) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;
endmodule

// ----- hdl/rpwc_back.sv -----
// ----------------------------------------------------------------------------
// rpwc_back: cluster table scan
// Walks every open entry one per cycle, joins matches, opens new entries.
// ----------------------------------------------------------------------------
module rpwc_back #(
  parameter int MAX_CLUSTERS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  rpwc_pkg::rpwc_job_t job,
  input  logic [15:0]         window_size,
  output logic                job_ready,
  output logic                res_valid,
  output rpwc_pkg::rpwc_out_t res
);
  import rpwc_pkg::*;

  localparam int IW = $clog2(MAX_CLUSTERS);

  // Entry layout: chrom, rev, read pos, mate pos.
  localparam int EW = 4 + 2 * POS_BITS;

  logic [EW-1:0] ent_mem [MAX_CLUSTERS];
  logic [15:0]   cnt_mem [MAX_CLUSTERS];

  rpwc_bk_state_t st_r, st_nxt;
  logic [IW:0]    fill_r, fill_nxt;
  logic [IW:0]    scan_r, scan_nxt;
  logic           rd_v_r;
  logic [IW-1:0]  rd_idx_r;
  logic [EW-1:0]  rd_ent_r;
  logic [15:0]    rd_cnt_r;
  rpwc_job_t      cur_r;
  logic           found_r, found_nxt;
  logic [8:0]     joined_r, joined_nxt;
  logic [IW-1:0]  first_r, first_nxt;
  rpwc_out_t      res_r, res_nxt;
  logic           res_valid_r, res_valid_nxt;
  logic           hit;
  logic [POS_BITS-1:0] arp, amp, jrp, jmp;
  logic [POS_BITS-1:0] dr, dm;
  logic           do_open, do_inc;

  always_comb begin
    arp = rd_ent_r[2*POS_BITS-1:POS_BITS];
    amp = rd_ent_r[POS_BITS-1:0];
    jrp = cur_r.read_pos[POS_BITS-1:0];
    jmp = cur_r.mate_pos[POS_BITS-1:0];
    dr  = (jrp > arp) ? jrp - arp : arp - jrp;
    dm  = (jmp > amp) ? jmp - amp : amp - jmp;
    hit = rd_v_r && rd_ent_r[EW-1:EW-3] == cur_r.chrom
          && rd_ent_r[EW-4] == cur_r.rev
          && {{(32-POS_BITS){1'b0}}, dr} < {16'd0, window_size}
          && {{(32-POS_BITS){1'b0}}, dm} < {16'd0, window_size};
  end

  always_comb begin
    st_nxt        = st_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    joined_nxt    = joined_r;
    first_nxt     = first_r;
    res_nxt       = res_r;
    res_valid_nxt = 1'b0;
    do_open       = 1'b0;
    do_inc        = hit;
    if (hit) begin
      if (!found_r) first_nxt = rd_idx_r;
      found_nxt = 1'b1;
      if (joined_r != JOIN_MAX) joined_nxt = joined_r + 9'd1;
    end
    case (st_r)
      BK_IDLE: begin
        scan_nxt   = '0;
        found_nxt  = 1'b0;
        joined_nxt = '0;
        if (job_valid) begin
          if (job.kept) begin
            st_nxt = BK_SCAN;
          end else begin
            res_nxt = '0;
            res_nxt.status = job.status;
            res_valid_nxt  = 1'b1;
          end
        end
      end
      BK_SCAN: begin
        if (scan_r < fill_r) begin
          scan_nxt = scan_r + (IW+1)'(1);
        end else begin
          st_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        // last entry was checked in the final scan cycle
        if (!rd_v_r) begin
          st_nxt  = BK_IDLE;
          res_nxt = '0;
          res_nxt.is_reverse = cur_r.rev;
          res_valid_nxt = 1'b1;
          if (found_nxt) begin
            res_nxt.status        = ST_JOINED;
            res_nxt.joined_count  = joined_nxt;
            res_nxt.cluster_index = 8'(first_nxt);
          end else if (fill_r < (IW+1)'(MAX_CLUSTERS)) begin
            do_open  = 1'b1;
            fill_nxt = fill_r + (IW+1)'(1);
            res_nxt.status        = ST_NEW;
            res_nxt.cluster_index = 8'(fill_r[IW-1:0]);
          end else begin
            res_nxt.status = ST_FULL;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Read pipeline: address issued in SCAN, data checked in the next cycle.
  always_ff @(posedge clk) begin
    rd_ent_r <= ent_mem[scan_r[IW-1:0]];
    rd_cnt_r <= cnt_mem[scan_r[IW-1:0]];
    rd_idx_r <= scan_r[IW-1:0];
    if (do_inc && rd_cnt_r != 16'hFFFF) begin
      cnt_mem[rd_idx_r] <= rd_cnt_r + 16'd1;
    end
    if (do_open) begin
      ent_mem[fill_r[IW-1:0]] <= {cur_r.chrom, cur_r.rev, jrp, jmp};
      cnt_mem[fill_r[IW-1:0]] <= 16'd1;
    end
    if (st_r == BK_IDLE && job_valid) cur_r <= job;
    found_r  <= found_nxt;
    joined_r <= joined_nxt;
    first_r  <= first_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      fill_r      <= '0;
      scan_r      <= '0;
      rd_v_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      rd_v_r      <= (st_r == BK_SCAN) && (scan_r < fill_r);
      res_valid_r <= res_valid_nxt;
    end
  end

  assign job_ready = (st_r == BK_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;
endmodule

// ----- hdl/rpwc_queue.sv -----
// ----------------------------------------------------------------------------
// rpwc_queue: two-entry job queue between filter and scanner
// ----------------------------------------------------------------------------
module rpwc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  rpwc_pkg::rpwc_job_t wr_data,
  input  logic                rd_en,
  output logic                rd_valid,
  output rpwc_pkg::rpwc_job_t rd_data,
  output logic                full
);
  import rpwc_pkg::*;

  rpwc_job_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en && rd_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en && rd_valid};
    end
  end

  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = q_r[rp_r];
  assign full     = (cnt_r == 2'd2);
endmodule

// ----- hdl/read_pair_window_clusterer.sv -----
// ----------------------------------------------------------------------------
// read_pair_window_clusterer: read pair filter and window clustering
// Filters aligned read pairs and groups kept reads into anchor clusters.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | transfer
//  --------+------------------------------------+------------------------------
//  input   | start, busy, in_item               | start high while busy low
//  result  | out_valid, out_item                | one cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_data        | cfg_we high, no wait
//
// A filtered-out read passes the filter register, the queue and the
// result register. A kept read walks all open entries, one per cycle
// through the entry RAM read port. Reset clears fill_level but not the
// entry RAMs; entries are never read past fill_level.
// busy stays high while the queue holds a job, the filter holds one, or
// the scanner is working. The result side cannot stall.
module read_pair_window_clusterer #(
  parameter int MAX_CLUSTERS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rpwc_pkg::rpwc_in_t  in_item,
  output logic                out_valid,
  output rpwc_pkg::rpwc_out_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [rpwc_pkg::CFG_W-1:0] cfg_data
);
  import rpwc_pkg::*;

  logic [15:0] window_r;
  logic [7:0]  min_qual_r;
  logic [27:0] min_span_r;

  // Configuration registers; out-of-range index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= 16'd3000;
      min_qual_r <= 8'd20;
      min_span_r <= 28'd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW:   window_r   <= cfg_data[15:0];
        REG_MIN_QUAL: min_qual_r <= cfg_data[7:0];
        REG_MIN_SPAN: min_span_r <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  logic      take;
  logic      fj_valid;
  rpwc_job_t fj;
  logic      q_valid, q_full, bk_ready;
  rpwc_job_t q_job;

  assign take = start && !busy;

  rpwc_front u_front (
    .clk, .rst_n, .take, .item(in_item),
    .min_quality(min_qual_r), .min_span(min_span_r),
    .job_valid(fj_valid), .job(fj)
  );

  rpwc_queue u_queue (
    .clk, .rst_n, .wr_en(fj_valid), .wr_data(fj),
    .rd_en(bk_ready), .rd_valid(q_valid), .rd_data(q_job), .full(q_full)
  );

  rpwc_back #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_back (
    .clk, .rst_n, .job_valid(q_valid), .job(q_job),
    .window_size(window_r), .job_ready(bk_ready),
    .res_valid(out_valid), .res(out_item)
  );

  // One read at a time keeps table order equal to arrival order.
  assign busy = fj_valid || q_valid || q_full || !bk_ready;
endmodule

// ----- hdl/rpwc_checker.sv -----
// ----------------------------------------------------------------------------
// rpwc_checker: port-level checks on the clusterer
// ----------------------------------------------------------------------------
module rpwc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input rpwc_pkg::rpwc_out_t out_item
);
  import rpwc_pkg::*;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after transfer");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= ST_FULL) else $error("bad status");

  a_join_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_JOINED |-> out_item.joined_count == 9'd0)
    else $error("join count without join");

  a_joined_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_JOINED |-> out_item.joined_count != 9'd0)
    else $error("join with zero count");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
endmodule

bind read_pair_window_clusterer rpwc_checker u_rpwc_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item
);
